@@ rtl/core/id3p_pkg.sv @@
// Package for the ID3v2 tag text parser core.
// Holds the parse phase type, result set type, field codes and tag constants.
// No dependencies.
`default_nettype none

package id3p_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_EXT,
    PH_FRAME,
    PH_ENC,
    PH_TEXT,
    PH_SKIP,
    PH_DONE
  } phase_e;

  localparam logic [1:0] FIELD_ARTIST = 2'd0;
  localparam logic [1:0] FIELD_TITLE  = 2'd1;
  localparam logic [1:0] FIELD_REPORT = 2'd2;

  localparam int unsigned HdrLen  = 10;
  localparam int unsigned ExtLen  = 4;
  localparam logic [28:0] HdrLenW = 29'd10;
  localparam logic [7:0]  LimitReset = 8'd79;

  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_3 = 8'h33;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] VER_3 = 8'd3;
  localparam logic [7:0] VER_4 = 8'd4;
  localparam logic [7:0] ENC_UTF16 = 8'd1;
  localparam logic [7:0] BOM_LO = 8'hFF;
  localparam logic [7:0] BOM_HI = 8'hFE;
  localparam int unsigned ExtFlagBit = 6;

  // Results caused by one file byte, delivered char, terminator, report.
  typedef struct packed {
    logic        char_v;
    logic        term_v;
    logic        rep_v;
    logic        target;
    logic [7:0]  char_val;
    logic [28:0] rep_len;
  } result_set_t;

endpackage

`default_nettype wire

@@ rtl/core/id3v2_tag_text_parser_core.sv @@
// Top level of the ID3v2 tag text parser: parse state plus result register.
// Depends on id3p_pkg, id3p_parser and id3p_out_queue.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   byte_value_i, first_byte_i
//   out       output     out_valid_o / out_stall_i field_o, char_value_o, last_o, tag_length_o
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_text_limit_i
//
// A byte's results load into the result register at the edge that accepts it.
// A byte with one result or none keeps the rate at one byte per cycle while out_stall_i is low;
// a byte with two or three results (text end, tag end report) holds the input while the result
// register drains one word per cycle.
// A word held by out_stall_i holds the input until the stall drops.
// Reset starts a header parse with text limit 79; first_byte_i restarts it.
`default_nettype none

module id3v2_tag_text_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        first_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       field_o,
  output logic [7:0]       char_value_o,
  output logic             last_o,
  output logic [28:0]      tag_length_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_text_limit_i
);
  import id3p_pkg::*;

  result_set_t res;
  logic        can_load;
  logic        accept;

  assign in_stall_o  = ~can_load;
  assign accept      = in_valid_i & can_load;
  assign cfg_ready_o = 1'b1;

  id3p_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_value_i (byte_value_i),
    .first_byte_i (first_byte_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_limit_i  (cfg_text_limit_i),
    .res_o        (res)
  );

  id3p_out_queue u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .res_i        (res),
    .can_load_o   (can_load),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .field_o      (field_o),
    .char_value_o (char_value_o),
    .last_o       (last_o),
    .tag_length_o (tag_length_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/id3p_parser.sv @@
// Parse state and per-byte next-state logic of the ID3v2 tag text parser.
// Produces the result set caused by each accepted byte. Depends on id3p_pkg.
`default_nettype none

module id3p_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         byte_value_i,
  input  wire logic               first_byte_i,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_limit_i,
  output id3p_pkg::result_set_t   res_o
);
  import id3p_pkg::*;

  function automatic logic [27:0] syncsafe(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d);
    return {a[6:0], b[6:0], c[6:0], d[6:0]};
  endfunction

  phase_e      phase_q, phase_d, phase_c;
  logic [3:0]  bc_q, bc_d, bc_c;
  logic [1:0]  fc_q, fc_d, fc_c, fc_inc;
  logic [31:0] pos_q, pos_d, pos_c, pos_n;
  logic [31:0] br_q, br_d, br_dec, fsize;
  logic [28:0] len_q, len_d, len_calc, stop_len;
  logic        v3_q, v3_d;
  logic        tgt_q, tgt_d;
  logic        utf_q, utf_d;
  logic        bom_q, bom_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  limit_q;
  logic [7:0]  hdr_q [HdrLen];
  logic        hdr_wr;
  logic [3:0]  hdr_idx;
  logic [27:0] ss;
  logic        past_end, end_hit;
  logic        do_enter, do_stop, text_fin;
  logic        emit_char;
  logic [7:0]  char_val;
  logic        artist, title;

  always_comb begin
    phase_c = first_byte_i ? PH_HEADER : phase_q;
    bc_c    = first_byte_i ? 4'd0 : bc_q;
    fc_c    = first_byte_i ? 2'd0 : fc_q;
    pos_c   = first_byte_i ? 32'd0 : pos_q;
    pos_n   = (&pos_c) ? pos_c : pos_c + 32'd1;
    past_end = {3'b000, len_q} <= pos_n;
    br_dec  = br_q - 32'd1;
    artist  = hdr_q[0] == CH_T && hdr_q[1] == CH_P && hdr_q[2] == CH_E && hdr_q[3] == CH_1;
    title   = hdr_q[0] == CH_T && hdr_q[1] == CH_I && hdr_q[2] == CH_T && hdr_q[3] == CH_2;
    fsize   = v3_q ? {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]}
                   : {4'd0, syncsafe(hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7])};
    ss       = '0;
    len_calc = '0;

    phase_d = phase_c;
    bc_d    = bc_c;
    fc_d    = fc_c;
    fc_inc  = fc_c + 2'd1;
    pos_d   = pos_n;
    br_d    = br_q;
    len_d   = len_q;
    v3_d    = v3_q;
    tgt_d   = tgt_q;
    utf_d   = utf_q;
    bom_d   = bom_q;
    held_d  = held_q;
    hdr_wr  = 1'b0;
    hdr_idx = bc_c;
    end_hit = past_end;
    do_enter  = 1'b0;
    do_stop   = 1'b0;
    text_fin  = 1'b0;
    stop_len  = len_q;
    emit_char = 1'b0;
    char_val  = byte_value_i;

    unique case (phase_c)
      PH_HEADER: begin
        hdr_wr = 1'b1;
        bc_d   = bc_c + 4'd1;
        if (bc_c == 4'(HdrLen - 1)) begin
          bc_d     = 4'd0;
          ss       = syncsafe(hdr_q[6], hdr_q[7], hdr_q[8], byte_value_i);
          len_calc = {1'b0, ss} + HdrLenW;
          if (hdr_q[0] != CH_I || hdr_q[1] != CH_D || hdr_q[2] != CH_3) begin
            do_stop  = 1'b1;
            stop_len = '0;
          end else begin
            v3_d  = hdr_q[3] == VER_3;
            len_d = len_calc;
            if (hdr_q[3] != VER_3 && hdr_q[3] != VER_4) begin
              do_stop  = 1'b1;
              stop_len = len_calc;
            end else if (hdr_q[5][ExtFlagBit]) begin
              phase_d = PH_EXT;
            end else begin
              do_enter = 1'b1;
              end_hit  = ss == '0;
            end
          end
        end
      end
      PH_EXT: begin
        hdr_wr  = 1'b1;
        hdr_idx = {2'b00, bc_c[1:0]};
        bc_d    = bc_c + 4'd1;
        if (bc_c == 4'(ExtLen - 1)) begin
          bc_d = 4'd0;
          ss   = syncsafe(hdr_q[0], hdr_q[1], hdr_q[2], byte_value_i);
          if (ss > 28'(ExtLen)) begin
            br_d    = {4'd0, ss - 28'(ExtLen)};
            phase_d = PH_SKIP;
          end else begin
            br_d     = '0;
            do_enter = 1'b1;
          end
        end
      end
      PH_FRAME: begin
        hdr_wr = 1'b1;
        bc_d   = bc_c + 4'd1;
        if (bc_c == 4'(HdrLen - 1)) begin
          bc_d = 4'd0;
          if (hdr_q[0] == 8'd0 ||
              (hdr_q[0] == CH_3 && hdr_q[1] == CH_D && hdr_q[2] == CH_I)) begin
            do_stop = 1'b1;
          end else begin
            br_d = fsize;
            if ((artist || title) && fsize != '0) begin
              tgt_d   = title;
              phase_d = PH_ENC;
            end else if (fsize != '0) begin
              phase_d = PH_SKIP;
            end else begin
              do_enter = 1'b1;
            end
          end
        end
      end
      PH_ENC: begin
        utf_d = byte_value_i == ENC_UTF16;
        br_d  = br_dec;
        if (br_dec > {24'd0, limit_q}) begin
          phase_d = PH_SKIP;
        end else if (br_dec == '0) begin
          text_fin = 1'b1;
        end else begin
          phase_d = PH_TEXT;
          bc_d    = 4'd0;
        end
      end
      PH_TEXT: begin
        if (utf_q) begin
          unique case (bc_c)
            4'd0: begin
              held_d    = byte_value_i;
              bom_d     = br_q > 32'd2;
              emit_char = br_q == 32'd1;
              bc_d      = 4'd1;
            end
            4'd1: begin
              emit_char = !(bom_q && held_q == BOM_LO && byte_value_i == BOM_HI);
              char_val  = held_q;
              bc_d      = 4'd2;
            end
            4'd2: begin
              emit_char = 1'b1;
              bc_d      = 4'd3;
            end
            default: begin
              bc_d = 4'd2;
            end
          endcase
        end else begin
          emit_char = 1'b1;
        end
        br_d = br_dec;
        if (br_q == 32'd1) begin
          text_fin = 1'b1;
        end
      end
      PH_SKIP: begin
        if (br_q != '0) begin
          br_d = br_dec;
        end
        if (br_q == '0 || br_q == 32'd1) begin
          do_enter = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (text_fin) begin
      fc_d = fc_inc;
      if (fc_inc >= 2'd2) begin
        do_stop = 1'b1;
      end else begin
        do_enter = 1'b1;
      end
    end
    if (do_enter) begin
      if (end_hit) begin
        do_stop = 1'b1;
      end else begin
        phase_d = PH_FRAME;
        bc_d    = 4'd0;
      end
    end
    if (do_stop) begin
      phase_d = PH_DONE;
    end
  end

  always_comb begin
    res_o          = '0;
    res_o.char_v   = emit_char;
    res_o.term_v   = text_fin;
    res_o.rep_v    = do_stop;
    res_o.target   = tgt_q;
    res_o.char_val = char_val;
    res_o.rep_len  = stop_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      bc_q    <= '0;
      fc_q    <= '0;
      pos_q   <= '0;
      br_q    <= '0;
      len_q   <= '0;
      v3_q    <= 1'b0;
      tgt_q   <= 1'b0;
      utf_q   <= 1'b0;
      bom_q   <= 1'b0;
      limit_q <= LimitReset;
    end else begin
      if (accept_i) begin
        phase_q <= phase_d;
        bc_q    <= bc_d;
        fc_q    <= fc_d;
        pos_q   <= pos_d;
        br_q    <= br_d;
        len_q   <= len_d;
        v3_q    <= v3_d;
        tgt_q   <= tgt_d;
        utf_q   <= utf_d;
        bom_q   <= bom_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
      if (hdr_wr) begin
        hdr_q[hdr_idx] <= byte_value_i;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/id3p_out_queue.sv @@
// Result register of the ID3v2 tag text parser: holds one byte's result set
// and hands out its words one per cycle while out_stall_i is low. Depends on id3p_pkg.
`default_nettype none

module id3p_out_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire id3p_pkg::result_set_t res_i,
  output logic                      can_load_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                field_o,
  output logic [7:0]                char_value_o,
  output logic                      last_o,
  output logic [28:0]               tag_length_o
);
  import id3p_pkg::*;

  logic        cv_q, tv_q, rv_q;
  logic        tgt_q;
  logic [7:0]  ch_q;
  logic [28:0] len_q;
  logic        pop, single;

  assign out_valid_o = cv_q | tv_q | rv_q;
  assign pop         = out_valid_o & ~out_stall_i;
  assign single      = $countones({cv_q, tv_q, rv_q}) == 2'd1;
  assign can_load_o  = ~out_valid_o | (single & ~out_stall_i);

  assign field_o      = (!cv_q && !tv_q) ? FIELD_REPORT : (tgt_q ? FIELD_TITLE : FIELD_ARTIST);
  assign char_value_o = cv_q ? ch_q : 8'd0;
  assign last_o       = ~cv_q & tv_q;
  assign tag_length_o = (!cv_q && !tv_q) ? len_q : 29'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
      tv_q <= 1'b0;
      rv_q <= 1'b0;
    end else if (load_i) begin
      cv_q <= res_i.char_v;
      tv_q <= res_i.term_v;
      rv_q <= res_i.rep_v;
    end else if (pop) begin
      priority if (cv_q) begin
        cv_q <= 1'b0;
      end else if (tv_q) begin
        tv_q <= 1'b0;
      end else begin
        rv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tgt_q <= res_i.target;
      ch_q  <= res_i.char_val;
      len_q <= res_i.rep_len;
    end
  end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Testbench for id3v2_tag_text_parser_core: feeds generated audio file openings
// and checks each artist/title text word and tag end report against a local model.
// Depends on id3p_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import id3p_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       first;
  } file_byte_t;

  typedef struct packed {
    logic [1:0]  field;
    logic [7:0]  ch;
    logic        last;
    logic [28:0] len;
  } text_word_t;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseBytes = 20;
  localparam logic [7:0] EncLatin1 = 8'h00;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_value = '0;
  logic        first_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  field;
  logic [7:0]  char_value;
  logic        last;
  logic [28:0] tag_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_limit = '0;

  file_byte_t  pending_bytes[$];
  text_word_t  expected_words[$];
  logic [7:0]  file_buf[$];
  logic [7:0]  tag_body[$];
  int unsigned fail_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;

  // parser state mirror
  phase_e      walk_phase;
  logic [3:0]  walk_cnt;
  logic [7:0]  hdr_buf[10];
  logic [7:0]  tag_ver;
  logic [27:0] tag_sz;
  logic [31:0] remaining;
  logic        to_title;
  logic [7:0]  text_enc;
  logic [31:0] position;
  logic [1:0]  captured;
  logic [7:0]  held_char;
  logic        bom_ok;
  logic [7:0]  text_cap = LimitReset;

  id3v2_tag_text_parser_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .byte_value_i     (byte_value),
    .first_byte_i     (first_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .field_o          (field),
    .char_value_o     (char_value),
    .last_o           (last),
    .tag_length_o     (tag_length),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_text_limit_i (cfg_limit)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void clear_walk();
    walk_phase = PH_HEADER;
    walk_cnt = '0;
    foreach (hdr_buf[i]) hdr_buf[i] = '0;
    tag_ver = '0;
    tag_sz = '0;
    remaining = '0;
    to_title = 1'b0;
    text_enc = '0;
    position = '0;
    captured = '0;
    held_char = '0;
    bom_ok = 1'b0;
  endfunction

  function automatic logic [27:0] syncsafe28(logic [7:0] b0, logic [7:0] b1,
                                             logic [7:0] b2, logic [7:0] b3);
    return {b0[6:0], b1[6:0], b2[6:0], b3[6:0]};
  endfunction

  function automatic logic [28:0] tag_end();
    return {1'b0, tag_sz} + HdrLenW;
  endfunction

  function automatic logic [1:0] text_field();
    return to_title ? FIELD_TITLE : FIELD_ARTIST;
  endfunction

  function automatic void emit(logic [1:0] f, logic [7:0] c, logic l, logic [28:0] len);
    expected_words.push_back(text_word_t'{f, c, l, len});
  endfunction

  function automatic void finish_walk(logic [28:0] len);
    emit(FIELD_REPORT, '0, 1'b0, len);
    walk_phase = PH_DONE;
  endfunction

  function automatic void next_frame();
    if (position >= 32'(tag_end())) begin
      finish_walk(tag_end());
    end else begin
      walk_phase = PH_FRAME;
      walk_cnt = '0;
    end
  endfunction

  function automatic void close_text();
    emit(text_field(), '0, 1'b1, '0);
    captured++;
    if (captured >= 2) finish_walk(tag_end());
    else next_frame();
  endfunction

  function automatic void decode_frame();
    logic [31:0] frame_len;
    logic        artist;
    logic        title;
    if (hdr_buf[0] == 8'h00 || (hdr_buf[0] == CH_3 && hdr_buf[1] == CH_D && hdr_buf[2] == CH_I)) begin
      finish_walk(tag_end());
      return;
    end
    if (tag_ver == VER_3) frame_len = {hdr_buf[4], hdr_buf[5], hdr_buf[6], hdr_buf[7]};
    else frame_len = {4'b0, syncsafe28(hdr_buf[4], hdr_buf[5], hdr_buf[6], hdr_buf[7])};
    artist = hdr_buf[0] == CH_T && hdr_buf[1] == CH_P && hdr_buf[2] == CH_E && hdr_buf[3] == CH_1;
    title = hdr_buf[0] == CH_T && hdr_buf[1] == CH_I && hdr_buf[2] == CH_T && hdr_buf[3] == CH_2;
    remaining = frame_len;
    if ((artist || title) && frame_len != 0) begin
      to_title = title;
      walk_phase = PH_ENC;
    end else if (frame_len != 0) begin
      walk_phase = PH_SKIP;
    end else begin
      next_frame();
    end
  endfunction

  function automatic void take_text(logic [7:0] b);
    logic last_one;
    last_one = (remaining == 1);
    if (text_enc == ENC_UTF16) begin
      case (walk_cnt)
        4'd0: begin
          held_char = b;
          bom_ok = remaining > 2;
          if (last_one) emit(text_field(), b, 1'b0, '0);
          walk_cnt = 4'd1;
        end
        4'd1: begin
          if (!(bom_ok && held_char == BOM_LO && b == BOM_HI))
            emit(text_field(), held_char, 1'b0, '0);
          walk_cnt = 4'd2;
        end
        4'd2: begin
          emit(text_field(), b, 1'b0, '0);
          walk_cnt = 4'd3;
        end
        default: walk_cnt = 4'd2;
      endcase
    end else begin
      emit(text_field(), b, 1'b0, '0);
    end
    remaining--;
    if (remaining == 0) close_text();
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic first);
    logic [27:0] ext_sz;
    if (first) clear_walk();
    if (position != '1) position++;
    case (walk_phase)
      PH_HEADER: begin
        hdr_buf[walk_cnt] = b;
        walk_cnt++;
        if (walk_cnt >= HdrLen) begin
          walk_cnt = '0;
          if (hdr_buf[0] != CH_I || hdr_buf[1] != CH_D || hdr_buf[2] != CH_3) begin
            finish_walk('0);
          end else begin
            tag_ver = hdr_buf[3];
            tag_sz = syncsafe28(hdr_buf[6], hdr_buf[7], hdr_buf[8], hdr_buf[9]);
            if (tag_ver != VER_3 && tag_ver != VER_4) finish_walk(tag_end());
            else if (hdr_buf[5][ExtFlagBit]) walk_phase = PH_EXT;
            else next_frame();
          end
        end
      end
      PH_EXT: begin
        hdr_buf[walk_cnt[1:0]] = b;
        walk_cnt++;
        if (walk_cnt >= ExtLen) begin
          walk_cnt = '0;
          ext_sz = syncsafe28(hdr_buf[0], hdr_buf[1], hdr_buf[2], hdr_buf[3]);
          remaining = (ext_sz > ExtLen) ? 32'(ext_sz) - ExtLen : '0;
          if (remaining != 0) walk_phase = PH_SKIP;
          else next_frame();
        end
      end
      PH_FRAME: begin
        hdr_buf[walk_cnt] = b;
        walk_cnt++;
        if (walk_cnt >= HdrLen) begin
          walk_cnt = '0;
          decode_frame();
        end
      end
      PH_ENC: begin
        text_enc = b;
        remaining--;
        if (remaining > 32'(text_cap)) begin
          walk_phase = PH_SKIP;
        end else if (remaining == 0) begin
          close_text();
        end else begin
          walk_phase = PH_TEXT;
          walk_cnt = '0;
        end
      end
      PH_TEXT: take_text(b);
      PH_SKIP: begin
        if (remaining != 0) remaining--;
        if (remaining == 0) next_frame();
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_size(ref logic [7:0] q[$], input logic [31:0] v,
                                   input bit syncsafe_sizes);
    for (int i = 3; i >= 0; i--) begin
      if (syncsafe_sizes) q.push_back({1'($urandom_range(0, 1)), v[7*i +: 7]});
      else q.push_back(v[8*i +: 8]);
    end
  endfunction

  function automatic void add_frame(bit syncsafe_sizes);
    int unsigned pick;
    int unsigned frame_len;
    int unsigned text_len;
    logic [7:0]  enc;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      tag_body.push_back(CH_T);
      tag_body.push_back(CH_P);
      tag_body.push_back(CH_E);
      tag_body.push_back(CH_1);
    end else if (pick < 8) begin
      tag_body.push_back(CH_T);
      tag_body.push_back(CH_I);
      tag_body.push_back(CH_T);
      tag_body.push_back(CH_2);
    end else begin
      tag_body.push_back(8'($urandom_range(65, 90)));
      repeat (3) tag_body.push_back(8'($urandom_range(48, 90)));
    end
    if (pick < 8) begin
      case ($urandom_range(0, 9))
        0: frame_len = 0;
        1: frame_len = (text_cap <= 100) ? text_cap + 1 + $urandom_range(0, 2) : 3;
        default: frame_len = $urandom_range(1, 12);
      endcase
    end else begin
      frame_len = $urandom_range(0, 8);
    end
    put_size(tag_body, frame_len, syncsafe_sizes);
    repeat (2) tag_body.push_back(8'($urandom));
    if (frame_len != 0) begin
      text_len = frame_len;
      if (pick < 8) begin
        case ($urandom_range(0, 3))
          0: enc = EncLatin1;
          1, 2: enc = ENC_UTF16;
          default: enc = 8'($urandom);
        endcase
        tag_body.push_back(enc);
        text_len = frame_len - 1;
        if (enc == ENC_UTF16 && text_len >= 2 && $urandom_range(0, 1) == 1) begin
          tag_body.push_back(BOM_LO);
          tag_body.push_back(BOM_HI);
          text_len -= 2;
        end
      end
      repeat (text_len) tag_body.push_back(8'($urandom));
    end
  endfunction

  function automatic int unsigned queue_file();
    foreach (file_buf[i]) pending_bytes.push_back(file_byte_t'{file_buf[i], i == 0});
    return file_buf.size();
  endfunction

  function automatic int unsigned build_file();
    int unsigned pick;
    int unsigned keep;
    logic [31:0] tag_len;
    logic [7:0]  ver;
    logic [7:0]  flags;
    bit          ext;
    file_buf.delete();
    tag_body.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(10, 16)) file_buf.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 1) file_buf[0] = CH_I;
    end else if (pick < 16) begin
      ver = 8'($urandom);
      if (ver == VER_3 || ver == VER_4) ver = ver + 8'd2;
      file_buf.push_back(CH_I);
      file_buf.push_back(CH_D);
      file_buf.push_back(CH_3);
      file_buf.push_back(ver);
      repeat (6) file_buf.push_back(8'($urandom));
      repeat ($urandom_range(0, 3)) file_buf.push_back(8'($urandom));
    end else begin
      ext = ($urandom_range(0, 2) == 0);
      ver = ($urandom_range(0, 1) == 1) ? VER_3 : VER_4;
      if (ext) begin
        tag_len = $urandom_range(0, 10);
        put_size(tag_body, tag_len, 1'b1);
        repeat ((tag_len > ExtLen) ? tag_len - ExtLen : 0) tag_body.push_back(8'($urandom));
      end
      repeat ($urandom_range(1, 3)) add_frame(ver == VER_4);
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        repeat (10) tag_body.push_back(8'h00);
      end else if (pick == 1) begin
        tag_body.push_back(CH_3);
        tag_body.push_back(CH_D);
        tag_body.push_back(CH_I);
        repeat (7) tag_body.push_back(8'($urandom));
      end
      tag_len = tag_body.size();
      if (pick == 3) tag_len -= $urandom_range(0, (tag_len < 8) ? tag_len : 8);
      else if (pick < 2) tag_len += $urandom_range(0, 12);
      flags = 8'($urandom);
      flags[ExtFlagBit] = ext;
      file_buf.push_back(CH_I);
      file_buf.push_back(CH_D);
      file_buf.push_back(CH_3);
      file_buf.push_back(ver);
      file_buf.push_back(8'($urandom));
      file_buf.push_back(flags);
      put_size(file_buf, tag_len, 1'b1);
      foreach (tag_body[i]) file_buf.push_back(tag_body[i]);
      repeat ($urandom_range(0, 3)) file_buf.push_back(8'($urandom));
    end
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, file_buf.size() - 1);
      while (file_buf.size() > keep) void'(file_buf.pop_back());
    end
    return queue_file();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 20)
      $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [7:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_limit <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    text_cap = value;
  endtask

  always @(posedge clk_i) begin
    file_byte_t next_byte;
    if (rst_ni) begin
      if (in_valid && !in_stall) predict_byte(byte_value, first_byte);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          if (next_byte.first) sender_calm = ($urandom_range(0, 3) == 0);
          in_valid <= 1'b1;
          byte_value <= next_byte.value;
          first_byte <= next_byte.first;
          send_gap = pick_gap(sender_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    text_word_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected, field", 32'(field), '0);
        end else begin
          want = expected_words.pop_front();
          if (field !== want.field) report_mismatch("field", 32'(field), 32'(want.field));
          if (char_value !== want.ch) report_mismatch("char_value", 32'(char_value), 32'(want.ch));
          if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
          if (tag_length !== want.len)
            report_mismatch("tag_length", 32'(tag_length), 32'(want.len));
          if (want.field == FIELD_REPORT) receiver_calm = ($urandom_range(0, 3) == 0);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(receiver_calm);
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL id3v2_tag_text_parser_core");
        $finish;
      end
    end
  end

  initial begin
    int unsigned queued;
    logic [7:0]  limit_plan[4];
    clear_walk();
    limit_plan = '{LimitReset, 8'd1, 8'd255, 8'($urandom_range(2, 254))};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    file_buf = '{CH_I, CH_D, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA,
                 8'hFF, 8'h00};
    void'(queue_file());
    file_buf = '{CH_I, CH_D, CH_3, 8'h02, 8'h00, 8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h7F};
    void'(queue_file());
    for (int p = 0; p < 4; p++) begin
      if (p != 0) write_limit(limit_plan[p]);
      queued = 0;
      while (queued < PhaseBytes) queued += build_file();
      wait_idle();
    end
    if (fail_count == 0) begin
      $display("PASS id3v2_tag_text_parser_core");
    end else begin
      $display("FAIL id3v2_tag_text_parser_core");
    end
    $finish;
  end

endmodule
